// File: src/cau_pkg.sv
// Shared types and codes for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    // Operation codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_CONJ = 3'd4
    } t_mode;

    // Control bits that travel with each request down the divider stages
    typedef struct packed {
        logic valid;   // stage holds a request
        logic is_div;  // result comes from the divider lanes
        logic dz;      // divide with zero divisor
        logic neg_r;   // real quotient is negative
        logic neg_i;   // imaginary quotient is negative
        logic ovfh_r;  // real quotient does not fit, known before iterating
        logic ovfh_i;  // imaginary quotient does not fit
        logic dovf;    // saturation flag of a non-divide result
    } t_ctl;

endpackage

`default_nettype wire

// File: src/complex_arithmetic_unit.sv
// Pipelined complex add, subtract, multiply, divide and conjugate in signed fixed point.
`default_nettype none

// The unit takes one request per clock unless a held result stalls it, and returns one result
// per request, in order. It has one input stage with the multipliers, one stage for the sums,
// one for saturation and magnitudes, one that checks the quotient range and loads the divider,
// DATA_WIDTH restoring-division stages that each settle one quotient bit of both result parts,
// and the output register. Every operation travels through all stages, so results never
// reorder. When the output is held, the whole pipeline holds; an empty output register always
// lets the pipeline move.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // request channel
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [2:0]                  i_mode,
    input  wire  signed [DATA_WIDTH-1:0] i_a_real,
    input  wire  signed [DATA_WIDTH-1:0] i_a_imag,
    input  wire  signed [DATA_WIDTH-1:0] i_b_real,
    input  wire  signed [DATA_WIDTH-1:0] i_b_imag,
    // result channel
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_real,
    output logic signed [DATA_WIDTH-1:0] o_res_imag,
    output logic                        o_divide_by_zero,
    output logic                        o_overflow
);

    localparam int W  = DATA_WIDTH;
    localparam int W2 = 2 * DATA_WIDTH;        // product width
    localparam int PW = 2 * DATA_WIDTH + 1;    // sum of two products
    localparam int NW = 2 * DATA_WIDTH + FRAC_BITS;  // scaled numerator magnitude
    localparam int HW = DATA_WIDTH + FRAC_BITS;      // numerator bits above the quotient
    localparam int CW = (HW > W2) ? HW : W2;          // range compare width

    localparam logic signed [PW-1:0] SAT_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] Q_POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] Q_NEG_MAX = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] RES_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] RES_MIN = {1'b1, {(W-1){1'b0}}};

    // saturate a wide signed value to W bits, flag in the top bit
    function automatic logic [W:0] sat_pw(input logic signed [PW-1:0] v);
        logic [W:0] res;
        if (v > SAT_MAX) begin
            res = {1'b1, SAT_MAX[W-1:0]};
        end else if (v < SAT_MIN) begin
            res = {1'b1, SAT_MIN[W-1:0]};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    logic en;

    // Stall the whole pipeline only while a finished result waits
    assign en      = i_ready || !o_valid;
    assign o_ready = en;

    // ---------------- stage 1: products and short sums ----------------
    logic                 r1_v;
    t_mode                r1_mode;
    logic signed [W2-1:0] r1_prr, r1_pii, r1_pri, r1_pir;
    logic        [W2-1:0] r1_pbr, r1_pbi;
    logic signed [W:0]    r1_sr, r1_si;
    logic signed [W:0]    n_sr, n_si;

    // Form add, subtract and conjugate results
    always_comb begin
        unique case (t_mode'(i_mode))
            MODE_ADD: begin
                n_sr = $signed({i_a_real[W-1], i_a_real}) + $signed({i_b_real[W-1], i_b_real});
                n_si = $signed({i_a_imag[W-1], i_a_imag}) + $signed({i_b_imag[W-1], i_b_imag});
            end
            MODE_SUB: begin
                n_sr = $signed({i_a_real[W-1], i_a_real}) - $signed({i_b_real[W-1], i_b_real});
                n_si = $signed({i_a_imag[W-1], i_a_imag}) - $signed({i_b_imag[W-1], i_b_imag});
            end
            MODE_CONJ: begin
                n_sr = $signed({i_a_real[W-1], i_a_real});
                n_si = -$signed({i_a_imag[W-1], i_a_imag});
            end
            default: begin
                n_sr = '0;
                n_si = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mode <= t_mode'(i_mode);
            r1_prr  <= W2'(i_a_real) * W2'(i_b_real);
            r1_pii  <= W2'(i_a_imag) * W2'(i_b_imag);
            r1_pri  <= W2'(i_a_real) * W2'(i_b_imag);
            r1_pir  <= W2'(i_a_imag) * W2'(i_b_real);
            r1_pbr  <= W2'(i_b_real) * W2'(i_b_real);
            r1_pbi  <= W2'(i_b_imag) * W2'(i_b_imag);
            r1_sr   <= n_sr;
            r1_si   <= n_si;
        end
    end

    // ---------------- stage 2: full-precision sums ----------------
    logic                 r2_v;
    t_mode                r2_mode;
    logic signed [PW-1:0] r2_dr, r2_di, r2_nr, r2_ni;
    logic        [W2-1:0] r2_den;
    logic signed [PW-1:0] n_mr, n_mi, n_dr, n_di;

    // Pick the non-divide result, multiply shifted down by the fraction bits
    always_comb begin
        n_mr = $signed({r1_prr[W2-1], r1_prr}) - $signed({r1_pii[W2-1], r1_pii});
        n_mi = $signed({r1_pri[W2-1], r1_pri}) + $signed({r1_pir[W2-1], r1_pir});
        if (r1_mode == MODE_MUL) begin
            n_dr = n_mr >>> FRAC_BITS;
            n_di = n_mi >>> FRAC_BITS;
        end else begin
            n_dr = {{(PW-W-1){r1_sr[W]}}, r1_sr};
            n_di = {{(PW-W-1){r1_si[W]}}, r1_si};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mode <= r1_mode;
            r2_dr   <= n_dr;
            r2_di   <= n_di;
            r2_nr   <= $signed({r1_prr[W2-1], r1_prr}) + $signed({r1_pii[W2-1], r1_pii});
            r2_ni   <= $signed({r1_pir[W2-1], r1_pir}) - $signed({r1_pri[W2-1], r1_pri});
            r2_den  <= r1_pbr + r1_pbi;
        end
    end

    // ---------------- stage 3: saturation, magnitudes, zero divisor ----------------
    logic                 r3_v;
    logic                 r3_is_div, r3_dz, r3_dovf;
    logic                 r3_neg_r, r3_neg_i;
    logic signed [W-1:0]  r3_dres_r, r3_dres_i;
    logic        [W2-1:0] r3_mag_r, r3_mag_i, r3_den;
    logic        [W:0]    n_sat_r, n_sat_i;
    logic signed [PW-1:0] n_abs_r, n_abs_i;

    // Clip the direct result and take numerator magnitudes
    always_comb begin
        n_sat_r = sat_pw(r2_dr);
        n_sat_i = sat_pw(r2_di);
        n_abs_r = r2_nr[PW-1] ? -r2_nr : r2_nr;
        n_abs_i = r2_ni[PW-1] ? -r2_ni : r2_ni;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_is_div <= (r2_mode == MODE_DIV);
            r3_dz     <= (r2_mode == MODE_DIV) && (r2_den == '0);
            r3_dovf   <= n_sat_r[W] || n_sat_i[W];
            r3_dres_r <= n_sat_r[W-1:0];
            r3_dres_i <= n_sat_i[W-1:0];
            r3_neg_r  <= r2_nr[PW-1];
            r3_neg_i  <= r2_ni[PW-1];
            r3_mag_r  <= n_abs_r[W2-1:0];
            r3_mag_i  <= n_abs_i[W2-1:0];
            r3_den    <= r2_den;
        end
    end

    // ---------------- stage 4: range check and divider load ----------------
    t_ctl                r_ctl   [0:W];
    logic [W2-1:0]       r_den   [0:W];
    logic [W2-1:0]       r_rem_r [0:W];
    logic [W2-1:0]       r_rem_i [0:W];
    logic [W-1:0]        r_low_r [0:W];
    logic [W-1:0]        r_low_i [0:W];
    logic [W-1:0]        r_q_r   [0:W];
    logic [W-1:0]        r_q_i   [0:W];
    logic signed [W-1:0] r_dres_r[0:W];
    logic signed [W-1:0] r_dres_i[0:W];

    logic [NW-1:0] n_num_r, n_num_i;
    logic [CW-1:0] n_hi_r, n_hi_i, n_den_c;
    t_ctl          n_ctl0;

    // Scale numerators; a quotient of 2^W or more is out of range outright
    always_comb begin
        n_num_r = NW'(r3_mag_r) << FRAC_BITS;
        n_num_i = NW'(r3_mag_i) << FRAC_BITS;
        n_hi_r  = CW'(n_num_r[NW-1:W]);
        n_hi_i  = CW'(n_num_i[NW-1:W]);
        n_den_c = CW'(r3_den);
        n_ctl0.valid  = r3_v;
        n_ctl0.is_div = r3_is_div;
        n_ctl0.dz     = r3_dz;
        n_ctl0.neg_r  = r3_neg_r;
        n_ctl0.neg_i  = r3_neg_i;
        n_ctl0.ovfh_r = (n_hi_r >= n_den_c);
        n_ctl0.ovfh_i = (n_hi_i >= n_den_c);
        n_ctl0.dovf   = r3_dovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (en) begin
            r_ctl[0] <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den[0]    <= r3_den;
            r_rem_r[0]  <= n_hi_r[W2-1:0];
            r_rem_i[0]  <= n_hi_i[W2-1:0];
            r_low_r[0]  <= n_num_r[W-1:0];
            r_low_i[0]  <= n_num_i[W-1:0];
            r_q_r[0]    <= '0;
            r_q_i[0]    <= '0;
            r_dres_r[0] <= r3_dres_r;
            r_dres_i[0] <= r3_dres_i;
        end
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_div
            logic [W2:0]   t_r, t_i, d_r, d_i;
            logic          ge_r, ge_i;
            logic [W2-1:0] n_rem_r, n_rem_i;

            // Bring down the next numerator bit and subtract where it fits
            always_comb begin
                t_r     = {r_rem_r[k], r_low_r[k][W-1]};
                t_i     = {r_rem_i[k], r_low_i[k][W-1]};
                ge_r    = (t_r >= {1'b0, r_den[k]});
                ge_i    = (t_i >= {1'b0, r_den[k]});
                d_r     = t_r - {1'b0, r_den[k]};
                d_i     = t_i - {1'b0, r_den[k]};
                n_rem_r = ge_r ? d_r[W2-1:0] : t_r[W2-1:0];
                n_rem_i = ge_i ? d_i[W2-1:0] : t_i[W2-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[k+1] <= '0;
                end else if (en) begin
                    r_ctl[k+1] <= r_ctl[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_den[k+1]    <= r_den[k];
                    r_rem_r[k+1]  <= n_rem_r;
                    r_rem_i[k+1]  <= n_rem_i;
                    r_low_r[k+1]  <= r_low_r[k] << 1;
                    r_low_i[k+1]  <= r_low_i[k] << 1;
                    r_q_r[k+1]    <= {r_q_r[k][W-2:0], ge_r};
                    r_q_i[k+1]    <= {r_q_i[k][W-2:0], ge_i};
                    r_dres_r[k+1] <= r_dres_r[k];
                    r_dres_i[k+1] <= r_dres_i[k];
                end
            end
        end
    endgenerate

    // ---------------- output stage: sign, saturation, result select ----------------
    logic                r_out_v;
    logic signed [W-1:0] r_out_r, r_out_i;
    logic                r_out_dz, r_out_ovf;
    logic signed [W-1:0] n_res_r, n_res_i, n_qs_r, n_qs_i;
    logic                n_ovf, n_qo_r, n_qo_i;
    t_ctl                c_last;

    // Apply the quotient sign and clip to the result range
    always_comb begin
        c_last = r_ctl[W];
        if (c_last.neg_r) begin
            n_qo_r = c_last.ovfh_r || (r_q_r[W] > Q_NEG_MAX);
            n_qs_r = n_qo_r ? RES_MIN : -$signed(r_q_r[W]);
        end else begin
            n_qo_r = c_last.ovfh_r || (r_q_r[W] > Q_POS_MAX);
            n_qs_r = n_qo_r ? RES_MAX : $signed(r_q_r[W]);
        end
        if (c_last.neg_i) begin
            n_qo_i = c_last.ovfh_i || (r_q_i[W] > Q_NEG_MAX);
            n_qs_i = n_qo_i ? RES_MIN : -$signed(r_q_i[W]);
        end else begin
            n_qo_i = c_last.ovfh_i || (r_q_i[W] > Q_POS_MAX);
            n_qs_i = n_qo_i ? RES_MAX : $signed(r_q_i[W]);
        end
        if (!c_last.is_div) begin
            n_res_r = r_dres_r[W];
            n_res_i = r_dres_i[W];
            n_ovf   = c_last.dovf;
        end else if (c_last.dz) begin
            n_res_r = '0;
            n_res_i = '0;
            n_ovf   = 1'b0;
        end else begin
            n_res_r = n_qs_r;
            n_res_i = n_qs_i;
            n_ovf   = n_qo_r || n_qo_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= c_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_r   <= n_res_r;
            r_out_i   <= n_res_i;
            r_out_dz  <= c_last.dz;
            r_out_ovf <= n_ovf;
        end
    end

    assign o_valid          = r_out_v;
    assign o_res_real       = r_out_r;
    assign o_res_imag       = r_out_i;
    assign o_divide_by_zero = r_out_dz;
    assign o_overflow       = r_out_ovf;

`ifndef SYNTH
    // A zero divisor yields a clean zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |->
            (o_res_real == '0) && (o_res_imag == '0) && !o_overflow)
        else $error("divide by zero result not cleared");

    // Overflow means some part sits at a range limit
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |->
            (o_res_real == RES_MAX) || (o_res_real == RES_MIN) ||
            (o_res_imag == RES_MAX) || (o_res_imag == RES_MIN))
        else $error("overflow flagged without a saturated part");

    // An empty output register never blocks new requests
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");

    // Divider stages only move when the pipeline advances
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_ctl[W]) && $stable(r_q_r[W]) && o_valid)
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

// File: test/tb_complex_arithmetic_unit.sv
// Self-checking testbench for the pipelined complex arithmetic unit.
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int FRAC = 8;
    localparam int W = 16;
    localparam int LATENCY = W + 5;
    localparam int RANDOM_ITEMS = 1930;
    localparam int DRAIN_EVERY = 700;
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD = 150;
    localparam int STALL_LIMIT = 4000;
    localparam int MODE_CODES = 8;

    localparam logic [W-1:0] OPND_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] OPND_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] OPND_NEG1 = {W{1'b1}};
    localparam logic [W-1:0] Q_ONE = W'(1 << FRAC);
    localparam longint SCALE = 64'sd1 <<< FRAC;
    localparam longint SAT_HI = (64'sd1 <<< (W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // One request as offered to the unit, plus a flag that holds it back
    // until every earlier result has come out
    typedef struct packed {
        logic [2:0]   mode;
        logic [W-1:0] a_real;
        logic [W-1:0] a_imag;
        logic [W-1:0] b_real;
        logic [W-1:0] b_imag;
        logic         wait_idle;
    } t_req;

    typedef struct packed {
        logic [W-1:0] res_real;
        logic [W-1:0] res_imag;
        logic         dz;
        logic         ovf;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_ready;
    logic [2:0]   i_mode = '0;
    logic [W-1:0] i_a_real = '0;
    logic [W-1:0] i_a_imag = '0;
    logic [W-1:0] i_b_real = '0;
    logic [W-1:0] i_b_imag = '0;
    logic         o_valid;
    logic         i_ready = 1'b0;
    logic [W-1:0] o_res_real;
    logic [W-1:0] o_res_imag;
    logic         o_divide_by_zero;
    logic         o_overflow;

    t_req pend_q[$];
    t_res expect_q[$];
    t_req cur_req = '0;
    int   send_gap = 0;
    int   sent_cnt = 0;
    int   got_cnt = 0;
    int   err_cnt = 0;
    int   total_items = 0;
    int   hold_left = 0;
    bit   long_hold_done = 1'b0;

    complex_arithmetic_unit #(
        .FRAC_BITS  (FRAC),
        .DATA_WIDTH (W)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_a_real         (i_a_real),
        .i_a_imag         (i_a_imag),
        .i_b_real         (i_b_real),
        .i_b_imag         (i_b_imag),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_res_real       (o_res_real),
        .o_res_imag       (o_res_imag),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflow       (o_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Clip one result part to the output width; top bit reports clipping
    function automatic logic [W:0] clamp_part(longint v);
        if (v > SAT_HI) return {1'b1, W'(SAT_HI)};
        if (v < SAT_LO) return {1'b1, W'(SAT_LO)};
        return {1'b0, v[W-1:0]};
    endfunction

    // Compute the result the unit must return for one request
    function automatic t_res complex_result(t_req r);
        longint ar, ai, br, bi, re, im, den;
        logic [W:0] sr, si;
        t_res res;
        ar = longint'($signed(r.a_real));
        ai = longint'($signed(r.a_imag));
        br = longint'($signed(r.b_real));
        bi = longint'($signed(r.b_imag));
        re = 0;
        im = 0;
        res = '0;
        case (r.mode)
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = (ar * br - ai * bi) >>> FRAC;
                im = (ar * bi + ai * br) >>> FRAC;
            end
            MODE_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    res.dz = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    re = ((ar * br + ai * bi) * SCALE) / den;
                    im = ((ai * br - ar * bi) * SCALE) / den;
                end
            end
            MODE_CONJ: begin
                re = ar;
                im = -ai;
            end
            default: ;
        endcase
        sr = clamp_part(re);
        si = clamp_part(im);
        res.res_real = sr[W-1:0];
        res.res_imag = si[W-1:0];
        res.ovf = sr[W] | si[W];
        return res;
    endfunction

    // Mostly no pause, sometimes a short one, rarely a long one
    function automatic int pick_pause(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 80) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix extremes, tiny, moderate and full-range operands
    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return OPND_MAX;
            1: return OPND_MIN;
            2: return W'($urandom_range(0, 32) - 16);
            3, 4, 5: return W'($urandom_range(0, 4096) - 2048);
            default: return W'($urandom);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) r.mode = MODE_ADD;
        else if (pick < 30) r.mode = MODE_SUB;
        else if (pick < 55) r.mode = MODE_MUL;
        else if (pick < 85) r.mode = MODE_DIV;
        else if (pick < 95) r.mode = MODE_CONJ;
        else r.mode = 3'($urandom_range(int'(MODE_CONJ) + 1, MODE_CODES - 1));
        r.a_real = rand_operand();
        r.a_imag = rand_operand();
        r.b_real = rand_operand();
        r.b_imag = rand_operand();
        if (r.mode == MODE_DIV && $urandom_range(0, 19) == 0) begin
            r.b_real = '0;
            r.b_imag = '0;
        end
        r.wait_idle = 1'b0;
        return r;
    endfunction

    task automatic queue_req(logic [2:0] mode, logic [W-1:0] ar, logic [W-1:0] ai,
                             logic [W-1:0] br, logic [W-1:0] bi);
        t_req r;
        r = '{mode: mode, a_real: ar, a_imag: ai, b_real: br, b_imag: bi, wait_idle: 1'b0};
        pend_q.push_back(r);
    endtask

    // Offer pending requests, hold each until accepted, with a random pause, often none, between them
    always @(posedge i_clk) begin : req_driver
        bit offering;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offering = i_valid;
            if (i_valid && o_ready) begin
                expect_q.push_back(complex_result(cur_req));
                sent_cnt++;
                offering = 1'b0;
                send_gap = pick_pause(((sent_cnt / 300) % 4) == 1);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0 &&
                             (!pend_q[0].wait_idle || got_cnt == sent_cnt)) begin
                    cur_req = pend_q.pop_front();
                    offering = 1'b1;
                end
            end
            i_valid  <= offering;
            i_mode   <= cur_req.mode;
            i_a_real <= cur_req.a_real;
            i_a_imag <= cur_req.a_imag;
            i_b_real <= cur_req.b_real;
            i_b_imag <= cur_req.b_imag;
        end
    end

    // Drive result ready: random stalls, one long hold to back up the pipeline
    always @(posedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!long_hold_done && got_cnt >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else begin
            hold_left = pick_pause(((got_cnt / 300) % 4) == 1);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_res seen, want;
        if (i_rst_n && o_valid && i_ready) begin
            seen = '{res_real: o_res_real, res_imag: o_res_imag,
                     dz: o_divide_by_zero, ovf: o_overflow};
            if (expect_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result re=%h im=%h dz=%b ovf=%b", $time,
                         seen.res_real, seen.res_imag, seen.dz, seen.ovf);
            end else begin
                want = expect_q.pop_front();
                got_cnt++;
                if (seen !== want) begin
                    err_cnt++;
                    $display("%0t: mismatch exp re=%h im=%h dz=%b ovf=%b", $time,
                             want.res_real, want.res_imag, want.dz, want.ovf);
                    $display("%0t:          got re=%h im=%h dz=%b ovf=%b", $time,
                             seen.res_real, seen.res_imag, seen.dz, seen.ovf);
                end
            end
        end
    end

    // End the run if neither channel moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout at %0t", $time);
        $display("FAIL complex_arithmetic_unit");
        $finish;
    end

    initial begin : stimulus
        t_req r;
        // Saturating add and subtract at the extremes
        queue_req(MODE_ADD, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        queue_req(MODE_ADD, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
        queue_req(MODE_ADD, '0, '0, '0, '0);
        queue_req(MODE_SUB, OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN);
        queue_req(MODE_SUB, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
        // Multiply: unit, extremes, floor of a negative product
        queue_req(MODE_MUL, Q_ONE, '0, Q_ONE, '0);
        queue_req(MODE_MUL, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        queue_req(MODE_MUL, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
        queue_req(MODE_MUL, OPND_MIN, '0, OPND_MIN, '0);
        queue_req(MODE_MUL, OPND_NEG1, '0, W'(1), '0);
        // Divide: zero divisor, ordinary, overflow, truncation toward zero
        queue_req(MODE_DIV, OPND_MAX, OPND_MIN, '0, '0);
        queue_req(MODE_DIV, '0, '0, '0, '0);
        queue_req(MODE_DIV, W'(3 * (1 << FRAC)), Q_ONE, W'(3 << (FRAC - 1)),
                  W'(-(1 << (FRAC - 1))));
        queue_req(MODE_DIV, OPND_MIN, OPND_MIN, W'(1), '0);
        queue_req(MODE_DIV, OPND_NEG1, '0, OPND_MAX, '0);
        queue_req(MODE_DIV, OPND_MAX, OPND_MAX, OPND_MIN, OPND_MIN);
        queue_req(MODE_DIV, OPND_NEG1, OPND_MAX, OPND_NEG1, OPND_NEG1);
        // Conjugate ignores b and clips the most negative imaginary part
        queue_req(MODE_CONJ, OPND_MAX, OPND_MIN, OPND_MAX, OPND_NEG1);
        queue_req(MODE_CONJ, OPND_MIN, OPND_MAX, '0, '0);
        // Unused mode codes return zero with both flags clear
        for (int k = int'(MODE_CONJ) + 1; k < MODE_CODES; k++)
            queue_req(3'(k), OPND_MAX, OPND_MIN, OPND_MAX, OPND_MIN);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = rand_req();
            r.wait_idle = (n % DRAIN_EVERY) == 0;
            pend_q.push_back(r);
        end
        total_items = pend_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < total_items) @(posedge i_clk);
        while (got_cnt < sent_cnt) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (err_cnt == 0 && expect_q.size() == 0) begin
            $display("PASS complex_arithmetic_unit");
        end else begin
            $display("FAIL complex_arithmetic_unit");
        end
        $finish;
    end

endmodule
